/* rtl/srb_pkg.sv */
package srb_pkg;

	// Sentence start marker
	localparam logic [7:0] DOLLAR_CHAR = 8'h24;

	// Request codes as they arrive on the input stream
	localparam int REQ_W = 3;
	localparam logic [REQ_W-1:0] REQ_ADD     = 3'd0;
	localparam logic [REQ_W-1:0] REQ_DEL     = 3'd1;
	localparam logic [REQ_W-1:0] REQ_REWIND  = 3'd2;
	localparam logic [REQ_W-1:0] REQ_RD_CUR  = 3'd3;
	localparam logic [REQ_W-1:0] REQ_RD_NEXT = 3'd4;

	typedef enum logic [2:0] {
		OP_NOP,
		OP_ADD,
		OP_DEL,
		OP_REWIND,
		OP_RD_CUR,
		OP_RD_NEXT
	} op_t;

	typedef struct packed {
		op_t        op;
		logic [7:0] char_in;
		logic       is_dollar;
	} cmd_t;

	// Head of the command queue, front to back
	typedef struct packed {
		logic valid;
		cmd_t cmd;
	} cmd_slot_t;

	// Back to front
	typedef struct packed {
		logic pop;
		logic clearing;
	} back_stat_t;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_READ,
		ST_WALK
	} back_state_t;

	typedef struct packed {
		logic       buffer_full;
		logic       buffer_empty;
		logic       sentence_ready;
		logic       read_valid;
		logic [7:0] read_char;
	} result_t;

endpackage

/* rtl/srb_front.sv */
module srb_front (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic [2:0]             req_type,
	input  logic [7:0]             char_in,
	input  srb_pkg::back_stat_t    back_stat,
	output srb_pkg::cmd_slot_t     cmd_slot
);

	logic [1:0]    count_q;
	logic          wr_ptr_q;
	logic          rd_ptr_q;
	srb_pkg::cmd_t fifo_q [2];
	srb_pkg::cmd_t cmd_new;
	logic          push;
	logic          pop;

	// Classify the request
	always_comb begin
		cmd_new.char_in   = char_in;
		cmd_new.is_dollar = (char_in == srb_pkg::DOLLAR_CHAR);
		case (req_type)
			srb_pkg::REQ_ADD:     cmd_new.op = srb_pkg::OP_ADD;
			srb_pkg::REQ_DEL:     cmd_new.op = srb_pkg::OP_DEL;
			srb_pkg::REQ_REWIND:  cmd_new.op = srb_pkg::OP_REWIND;
			srb_pkg::REQ_RD_CUR:  cmd_new.op = srb_pkg::OP_RD_CUR;
			srb_pkg::REQ_RD_NEXT: cmd_new.op = srb_pkg::OP_RD_NEXT;
			default:              cmd_new.op = srb_pkg::OP_NOP;
		endcase
	end

	assign in_ready = (count_q != 2'd2) && !back_stat.clearing;
	assign push     = in_valid && in_ready;
	assign pop      = back_stat.pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= 2'd0;
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
		end else begin
			if (push) wr_ptr_q <= !wr_ptr_q;
			if (pop)  rd_ptr_q <= !rd_ptr_q;
			case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) fifo_q[wr_ptr_q] <= cmd_new;
	end

	assign cmd_slot.valid = (count_q != 2'd0);
	assign cmd_slot.cmd   = fifo_q[rd_ptr_q];

endmodule

/* rtl/srb_back.sv */
module srb_back #(
	parameter int BUF_DEPTH = 256
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  srb_pkg::cmd_slot_t     cmd_slot,
	output srb_pkg::back_stat_t    back_stat,
	output logic                   out_valid,
	input  logic                   out_ready,
	output srb_pkg::result_t       result
);

	localparam int            AW       = $clog2(BUF_DEPTH);
	localparam logic [AW-1:0] LAST_POS = AW'(BUF_DEPTH - 1);

	function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] p);
		return (p == LAST_POS) ? '0 : p + 1'b1;
	endfunction

	srb_pkg::back_state_t state_q, state_d;

	logic [AW-1:0] start_q, start_d;
	logic [AW-1:0] end_q, end_d;
	logic [AW-1:0] cend_q, cend_d;
	logic [AW-1:0] cursor_q, cursor_d;
	logic [AW-1:0] walk_q, walk_d;
	logic [AW-1:0] clr_q;
	logic          full_q, full_d;
	logic          await_q, await_d;
	logic          out_valid_q;
	srb_pkg::result_t res_q, res_d;

	logic [7:0]    mem_q [BUF_DEPTH];
	logic [7:0]    rd_data_q;
	logic [AW-1:0] rd_addr;
	logic          mem_we;
	logic [AW-1:0] mem_waddr;
	logic [7:0]    mem_wdata;

	logic          slot_free;
	logic          take;
	logic          have;
	logic          walk_done;
	logic          res_load;
	logic [AW-1:0] end_inc;
	logic [AW-1:0] cur_inc;
	logic [AW-1:0] start_inc;
	logic [AW-1:0] walk_inc;

	assign slot_free = !out_valid_q || out_ready;
	assign take      = (state_q == srb_pkg::ST_IDLE) && cmd_slot.valid && slot_free;
	assign have      = (start_q != cend_q);
	assign walk_done = (walk_q == cend_q) || (rd_data_q == srb_pkg::DOLLAR_CHAR);
	assign end_inc   = wrap_inc(end_q);
	assign cur_inc   = wrap_inc(cursor_q);
	assign start_inc = wrap_inc(start_q);
	assign walk_inc  = wrap_inc(walk_q);

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			srb_pkg::ST_CLEAR: begin
				if (clr_q == LAST_POS) state_d = srb_pkg::ST_IDLE;
			end
			srb_pkg::ST_IDLE: begin
				if (take) begin
					case (cmd_slot.cmd.op)
						srb_pkg::OP_REWIND,
						srb_pkg::OP_RD_NEXT: state_d = srb_pkg::ST_READ;
						srb_pkg::OP_RD_CUR:  if (have) state_d = srb_pkg::ST_READ;
						srb_pkg::OP_DEL:     if (have) state_d = srb_pkg::ST_WALK;
						default:             state_d = srb_pkg::ST_IDLE;
					endcase
				end
			end
			srb_pkg::ST_READ: state_d = srb_pkg::ST_IDLE;
			srb_pkg::ST_WALK: if (walk_done) state_d = srb_pkg::ST_IDLE;
			default:          state_d = srb_pkg::ST_IDLE;
		endcase
	end

	// Datapath and outputs
	always_comb begin
		start_d   = start_q;
		end_d     = end_q;
		cend_d    = cend_q;
		cursor_d  = cursor_q;
		walk_d    = walk_q;
		full_d    = full_q;
		await_d   = await_q;
		mem_we    = 1'b0;
		mem_waddr = clr_q;
		mem_wdata = 8'h00;
		rd_addr   = cursor_q;
		res_load  = 1'b0;
		res_d.read_char  = 8'h00;
		res_d.read_valid = 1'b1;
		case (state_q)
			srb_pkg::ST_CLEAR: begin
				mem_we = 1'b1;
			end
			srb_pkg::ST_IDLE: begin
				if (take) begin
					case (cmd_slot.cmd.op)
						srb_pkg::OP_ADD: begin
							res_load = 1'b1;
							if (!full_q && (!await_q || cmd_slot.cmd.is_dollar)) begin
								await_d = 1'b0;
								if (end_inc == start_q) begin
									// drop the partial sentence
									full_d  = 1'b1;
									await_d = 1'b1;
									end_d   = cend_q;
								end else begin
									if (cmd_slot.cmd.is_dollar) cend_d = end_q;
									mem_we    = 1'b1;
									mem_waddr = end_q;
									mem_wdata = cmd_slot.cmd.char_in;
									end_d     = end_inc;
								end
							end
						end
						srb_pkg::OP_DEL: begin
							if (!have) begin
								res_load = 1'b1;
							end else begin
								walk_d  = start_inc;
								rd_addr = start_inc;
							end
						end
						srb_pkg::OP_REWIND: begin
							cursor_d = start_q;
							rd_addr  = start_q;
						end
						srb_pkg::OP_RD_CUR: begin
							if (!have) begin
								res_load         = 1'b1;
								res_d.read_valid = 1'b0;
							end
						end
						srb_pkg::OP_RD_NEXT: begin
							cursor_d = cur_inc;
							rd_addr  = cur_inc;
						end
						default: begin
							res_load = 1'b1;
						end
					endcase
				end
			end
			srb_pkg::ST_READ: begin
				res_load        = 1'b1;
				res_d.read_char = rd_data_q;
			end
			srb_pkg::ST_WALK: begin
				if (walk_done) begin
					start_d  = walk_q;
					full_d   = 1'b0;
					res_load = 1'b1;
				end else begin
					walk_d  = walk_inc;
					rd_addr = walk_inc;
				end
			end
			default: begin
				res_load = 1'b0;
			end
		endcase
		res_d.sentence_ready = (start_d != cend_d);
		res_d.buffer_empty   = (start_d == end_d);
		res_d.buffer_full    = full_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= srb_pkg::ST_CLEAR;
			start_q     <= '0;
			end_q       <= '0;
			cend_q      <= '0;
			cursor_q    <= '0;
			walk_q      <= '0;
			clr_q       <= '0;
			full_q      <= 1'b0;
			await_q     <= 1'b1;
			out_valid_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			start_q  <= start_d;
			end_q    <= end_d;
			cend_q   <= cend_d;
			cursor_q <= cursor_d;
			walk_q   <= walk_d;
			full_q   <= full_d;
			await_q  <= await_d;
			if (state_q == srb_pkg::ST_CLEAR) clr_q <= clr_q + 1'b1;
			if (res_load)       out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) res_q <= res_d;
	end

	always_ff @(posedge clk) begin
		if (mem_we) mem_q[mem_waddr] <= mem_wdata;
		rd_data_q <= mem_q[rd_addr];
	end

	assign back_stat.pop      = take;
	assign back_stat.clearing = (state_q == srb_pkg::ST_CLEAR);
	assign out_valid          = out_valid_q;
	assign result             = res_q;

endmodule

/* rtl/sentence_ring_buffer.sv */
// Path: adds, no-ops, and deletes and read-current requests that find no sentence go from the
// front queue to the result register; other reads also pass the registered read port.
// Throughput: 1 item per cycle while results are taken; store reads and deletes with a
// sentence hold off the next item until the read, or the walk to the next '$' or the
// complete-data end, is done. Reset: asynchronous, active low; afterwards the store is zeroed
// one entry per cycle, all BUF_DEPTH entries, during which s_axis_tready stays low.
module sentence_ring_buffer #(
	parameter int BUF_DEPTH = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] char_in
	input  logic [2:0]  s_axis_tuser,   // [2:0] req_type
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata,   // [7:0] read_char, [8] sentence_ready,
	                                    // [9] buffer_empty, [10] buffer_full, [15:11] zero
	output logic [0:0]  m_axis_tuser    // [0] read_valid
);

	srb_pkg::back_stat_t back_stat;
	srb_pkg::cmd_slot_t  cmd_slot;
	srb_pkg::result_t    result;

	// Front: accept each item, decode its request and hold it in a short queue
	srb_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.req_type  (s_axis_tuser),
		.char_in   (s_axis_tdata),
		.back_stat (back_stat),
		.cmd_slot  (cmd_slot)
	);

	// Back: own the character store and ring pointers, walk the store on delete
	// and hold each result in an output register until it is taken
	srb_back #(
		.BUF_DEPTH (BUF_DEPTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_slot  (cmd_slot),
		.back_stat (back_stat),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.result    (result)
	);

	// Pack the result item; pad the unused upper bits with zeros
	assign m_axis_tdata = {5'b00000, result.buffer_full, result.buffer_empty,
	                       result.sentence_ready, result.read_char};
	assign m_axis_tuser = result.read_valid;

endmodule

/* tb/sv/tb_sentence_ring_buffer.sv */
`timescale 1ns / 100ps

module tb_sentence_ring_buffer;

	localparam int DEPTH = 256;
	localparam int CYCLE_LIMIT = 2_000_000;
	// Items sent before the closing overflow sequence
	localparam int ITEM_TARGET = 900;

	// Request codes the block treats as no-ops
	localparam logic [2:0] REQ_SPARE5 = 3'd5;
	localparam logic [2:0] REQ_SPARE6 = 3'd6;
	localparam logic [2:0] REQ_SPARE7 = 3'd7;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata;   // [7:0] char_in
	logic [2:0]  s_axis_tuser;   // [2:0] req_type
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [15:0] m_axis_tdata;   // [7:0] read_char, [8] sentence_ready, [9] buffer_empty,
	                             // [10] buffer_full, [15:11] zero
	logic [0:0]  m_axis_tuser;   // [0] read_valid

	sentence_ring_buffer #(
		.BUF_DEPTH(DEPTH)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser)
	);

	// One request, optionally with a hand-written status it must produce
	typedef struct {
		logic             [2:0] req;
		logic             [7:0] ch;
		bit               pinned;
		srb_pkg::result_t want;
	} request_t;

	request_t  plan_q[$];      // directed table
	request_t  pin_q[$];       // one entry per item sent, in send order
	request_t  pinned;         // pin for the next item sent
	srb_pkg::result_t due_status_q[$]; // statuses still owed by the block

	// Shadow copy of the ring
	logic [7:0] shadow_store [DEPTH];
	logic [7:0] shadow_head;
	logic [7:0] shadow_tail;
	logic [7:0] shadow_done_end;
	logic [7:0] shadow_cursor;
	bit         shadow_full;
	bit         shadow_hunting;

	int  item_cnt;
	int  fail_cnt;
	int  cycle_cnt;
	bit  tx_calm;
	bit  rx_calm;
	int  rx_hold;

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic logic [7:0] ring_step(input logic [7:0] p);
		return (p == DEPTH - 1) ? 8'd0 : p + 8'd1;
	endfunction

	// Advance the shadow ring by one request and return the status the block must report
	function automatic srb_pkg::result_t ring_status_after(input logic [2:0] req,
			input logic [7:0] ch);
		srb_pkg::result_t r;
		logic [7:0] nxt;
		logic [7:0] p;
		r = '0;
		r.read_valid = 1'b1;
		case (req)
			srb_pkg::REQ_ADD: begin
				// Drop bytes while full or while hunting for the next sentence start
				if (!shadow_full && (!shadow_hunting || ch == srb_pkg::DOLLAR_CHAR)) begin
					shadow_hunting = 1'b0;
					nxt = ring_step(shadow_tail);
					if (nxt == shadow_head) begin
						// Overflow: discard the partial sentence and wait for a fresh start
						shadow_full = 1'b1;
						shadow_hunting = 1'b1;
						shadow_tail = shadow_done_end;
					end else begin
						if (ch == srb_pkg::DOLLAR_CHAR)
							shadow_done_end = shadow_tail;
						shadow_store[shadow_tail] = ch;
						shadow_tail = nxt;
					end
				end
			end
			srb_pkg::REQ_DEL: begin
				// Walk to the next stored '$' or to the end of the complete data
				if (shadow_head != shadow_done_end) begin
					p = shadow_head;
					do
						p = ring_step(p);
					while (p != shadow_done_end && shadow_store[p] != srb_pkg::DOLLAR_CHAR);
					shadow_head = p;
					shadow_full = 1'b0;
				end
			end
			srb_pkg::REQ_REWIND: begin
				shadow_cursor = shadow_head;
				r.read_char = shadow_store[shadow_cursor];
			end
			srb_pkg::REQ_RD_CUR: begin
				if (shadow_head != shadow_done_end)
					r.read_char = shadow_store[shadow_cursor];
				else
					r.read_valid = 1'b0;
			end
			srb_pkg::REQ_RD_NEXT: begin
				shadow_cursor = ring_step(shadow_cursor);
				r.read_char = shadow_store[shadow_cursor];
			end
			default: begin
			end
		endcase
		r.sentence_ready = (shadow_head != shadow_done_end);
		r.buffer_empty = (shadow_head == shadow_tail);
		r.buffer_full = shadow_full;
		return r;
	endfunction

	// Mostly back-to-back, now and then a short pause, rarely a long one
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		else if (r < 93)
			return $urandom_range(1, 3);
		else
			return $urandom_range(8, 40);
	endfunction

	// Hold the item until the block takes it, then idle for a random gap
	task automatic send_item(input logic [2:0] req, input logic [7:0] ch);
		int gap;
		pin_q.push_back(pinned);
		pinned.pinned = 1'b0;
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= req;
		s_axis_tdata <= ch;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		gap = tx_calm ? 0 : pick_gap();
		if (gap != 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Drop tvalid, then wait until every status owed has come back
	task automatic wait_drained();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (due_status_q.size() != 0)
			@(posedge clk);
	endtask

	// Delete until no complete sentence is left
	task automatic drop_all_sentences();
		wait_drained();
		while (shadow_head != shadow_done_end) begin
			send_item(srb_pkg::REQ_DEL, 8'h00);
			wait_drained();
		end
	endtask

	task automatic add_row(input logic [2:0] req, input logic [7:0] ch, input bit pin,
			input logic [7:0] rc, input bit rv, input bit sr, input bit emp, input bit full);
		request_t row;
		row.req = req;
		row.ch = ch;
		row.pinned = pin;
		row.want.read_char = rc;
		row.want.read_valid = rv;
		row.want.sentence_ready = sr;
		row.want.buffer_empty = emp;
		row.want.buffer_full = full;
		plan_q.push_back(row);
	endtask

	// Predict on every accepted item, check every accepted result
	always @(posedge clk) begin
		request_t         tag;
		srb_pkg::result_t want;
		srb_pkg::result_t got;
		if (arst_n && s_axis_tvalid && s_axis_tready) begin
			tag = pin_q.pop_front();
			want = ring_status_after(s_axis_tuser, s_axis_tdata);
			if (tag.pinned)
				want = tag.want;
			item_cnt++;
			due_status_q.push_back(want);
		end
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got.read_char = m_axis_tdata[7:0];
			got.sentence_ready = m_axis_tdata[8];
			got.buffer_empty = m_axis_tdata[9];
			got.buffer_full = m_axis_tdata[10];
			got.read_valid = m_axis_tuser[0];
			if (due_status_q.size() == 0) begin
				fail_cnt++;
				if (fail_cnt <= 10)
					$display("unexpected result at cycle %0d: char=%02h v=%0b r=%0b e=%0b f=%0b",
						cycle_cnt, got.read_char, got.read_valid, got.sentence_ready,
						got.buffer_empty, got.buffer_full);
			end else begin
				want = due_status_q.pop_front();
				if (got.read_char !== want.read_char || got.read_valid !== want.read_valid ||
						got.sentence_ready !== want.sentence_ready ||
						got.buffer_empty !== want.buffer_empty ||
						got.buffer_full !== want.buffer_full) begin
					fail_cnt++;
					if (fail_cnt <= 10)
						$display("mismatch at cycle %0d: exp %02h/%0b/%0b/%0b/%0b got %02h/%0b/%0b/%0b/%0b",
							cycle_cnt, want.read_char, want.read_valid, want.sentence_ready,
							want.buffer_empty, want.buffer_full, got.read_char, got.read_valid,
							got.sentence_ready, got.buffer_empty, got.buffer_full);
				end
			end
		end
	end

	// Result side back-pressure: stretches of stalls and stretches of none
	always @(posedge clk) begin
		if (rx_hold != 0) begin
			rx_hold--;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= 1'b1;
			if (!rx_calm && $urandom_range(0, 5) == 0)
				rx_hold = pick_gap();
		end
		if ($urandom_range(0, 299) == 0)
			rx_calm = !rx_calm;
	end

	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt >= CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	initial begin
		int       pick;
		int       len;
		logic [7:0] ch;
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = 8'h00;
		s_axis_tuser = srb_pkg::REQ_ADD;
		m_axis_tready = 1'b0;
		pinned.pinned = 1'b0;
		item_cnt = 0;
		fail_cnt = 0;
		cycle_cnt = 0;
		tx_calm = 1'b0;
		rx_calm = 1'b0;
		rx_hold = 0;

		// Shadow ring in its reset state
		for (int i = 0; i < DEPTH; i++)
			shadow_store[i] = 8'h00;
		shadow_head = '0;
		shadow_tail = '0;
		shadow_done_end = '0;
		shadow_cursor = '0;
		shadow_full = 1'b0;
		shadow_hunting = 1'b1;

		// Directed table: empty-ring reads, ignored bytes, spare codes, one sentence, its reads and deletes
		add_row(srb_pkg::REQ_RD_CUR,  8'h00, 1, 8'h00, 0, 0, 1, 0);
		add_row(srb_pkg::REQ_REWIND,  8'h00, 1, 8'h00, 1, 0, 1, 0);
		add_row(srb_pkg::REQ_RD_NEXT, 8'hFF, 1, 8'h00, 1, 0, 1, 0);
		add_row(srb_pkg::REQ_DEL,     8'h00, 1, 8'h00, 1, 0, 1, 0);
		add_row(srb_pkg::REQ_ADD,     8'h47, 1, 8'h00, 1, 0, 1, 0);
		add_row(srb_pkg::REQ_ADD,     8'hFF, 1, 8'h00, 1, 0, 1, 0);
		add_row(srb_pkg::REQ_ADD,     8'h00, 1, 8'h00, 1, 0, 1, 0);
		add_row(REQ_SPARE5,           8'h24, 1, 8'h00, 1, 0, 1, 0);
		add_row(REQ_SPARE6,           8'h00, 1, 8'h00, 1, 0, 1, 0);
		add_row(REQ_SPARE7,           8'hFF, 1, 8'h00, 1, 0, 1, 0);
		add_row(srb_pkg::REQ_ADD, srb_pkg::DOLLAR_CHAR, 1, 8'h00, 1, 0, 0, 0);
		add_row(srb_pkg::REQ_ADD,     8'h47, 0, 8'h00, 0, 0, 0, 0);
		add_row(srb_pkg::REQ_ADD,     8'h50, 0, 8'h00, 0, 0, 0, 0);
		add_row(srb_pkg::REQ_ADD,     8'h00, 0, 8'h00, 0, 0, 0, 0);
		add_row(srb_pkg::REQ_ADD,     8'hFF, 0, 8'h00, 0, 0, 0, 0);
		add_row(srb_pkg::REQ_ADD, srb_pkg::DOLLAR_CHAR, 0, 8'h00, 0, 0, 0, 0);
		add_row(srb_pkg::REQ_REWIND,  8'h00, 0, 8'h00, 0, 0, 0, 0);
		add_row(srb_pkg::REQ_RD_CUR,  8'h00, 0, 8'h00, 0, 0, 0, 0);
		add_row(srb_pkg::REQ_RD_NEXT, 8'h00, 0, 8'h00, 0, 0, 0, 0);
		add_row(srb_pkg::REQ_RD_NEXT, 8'h00, 0, 8'h00, 0, 0, 0, 0);
		add_row(srb_pkg::REQ_DEL,     8'h00, 0, 8'h00, 0, 0, 0, 0);
		add_row(srb_pkg::REQ_RD_CUR,  8'h00, 0, 8'h00, 0, 0, 0, 0);
		add_row(srb_pkg::REQ_DEL,     8'h00, 0, 8'h00, 0, 0, 0, 0);
		add_row(REQ_SPARE7,           8'h00, 0, 8'h00, 0, 0, 0, 0);

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// The block holds tready low while it clears its store; send_item just waits
		foreach (plan_q[i]) begin
			pinned = plan_q[i];
			send_item(plan_q[i].req, plan_q[i].ch);
		end

		// Random part: mostly whole sentences, mixed with deletes, read walks and noise
		while (item_cnt < ITEM_TARGET) begin
			if ($urandom_range(0, 29) == 0)
				tx_calm = !tx_calm;
			pick = $urandom_range(0, 99);
			if (pick < 55) begin
				len = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 140) : $urandom_range(2, 30);
				send_item(srb_pkg::REQ_ADD, srb_pkg::DOLLAR_CHAR);
				repeat (len) send_item(srb_pkg::REQ_ADD, 8'($urandom_range(0, 255)));
			end else if (pick < 75) begin
				repeat ($urandom_range(1, 4))
					send_item(srb_pkg::REQ_DEL, 8'($urandom_range(0, 255)));
			end else if (pick < 90) begin
				send_item(srb_pkg::REQ_REWIND, 8'($urandom_range(0, 255)));
				repeat ($urandom_range(1, 12))
					send_item(($urandom_range(0, 3) == 0) ? srb_pkg::REQ_RD_CUR :
						srb_pkg::REQ_RD_NEXT, 8'($urandom_range(0, 255)));
			end else begin
				repeat ($urandom_range(1, 6))
					send_item(3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)));
			end
		end

		// Finish with one sentence too long for the ring: it overflows with nothing
		// complete behind it, so adds stay blocked and deletes cannot clear the flag
		drop_all_sentences();
		send_item(srb_pkg::REQ_ADD, srb_pkg::DOLLAR_CHAR);
		drop_all_sentences();
		repeat (DEPTH + 40) begin
			ch = 8'($urandom_range(0, 255));
			if (ch == srb_pkg::DOLLAR_CHAR)
				ch = 8'h41;
			send_item(srb_pkg::REQ_ADD, ch);
		end
		send_item(srb_pkg::REQ_DEL, 8'h00);
		send_item(srb_pkg::REQ_ADD, srb_pkg::DOLLAR_CHAR);
		send_item(srb_pkg::REQ_RD_CUR, 8'h00);
		send_item(srb_pkg::REQ_REWIND, 8'h00);
		repeat (3) send_item(srb_pkg::REQ_RD_NEXT, 8'h00);
		s_axis_tvalid <= 1'b0;

		// Let the last results drain, then allow a few cycles for stray ones
		@(posedge clk);
		while (due_status_q.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);

		if (fail_cnt == 0 && due_status_q.size() == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule

/* sentence_ring_buffer.f */
rtl/srb_pkg.sv
rtl/srb_front.sv
rtl/srb_back.sv
rtl/sentence_ring_buffer.sv
tb/sv/tb_sentence_ring_buffer.sv
